FILE: hdl/tun_pkg.sv
`timescale 1ns / 1ps

package tun_pkg;

  localparam int CW  = 33;   // edge vector component
  localparam int PW  = 66;   // edge product
  localparam int NW  = 66;   // cross component, signed
  localparam int MW  = 65;   // cross component magnitude
  localparam int HW  = 33;   // upper split of magnitude
  localparam int LW  = 32;   // lower split of magnitude
  localparam int SQW = 130;  // squared component
  localparam int SW  = 132;  // sum of squares
  localparam int RW  = 168;  // cell residue and running product
  localparam int QW  = 15;   // magnitude bits of a Q1.14 component
  localparam int OW  = 16;   // output component
  localparam int WSH = 30;   // scale of squared component against the sum

  typedef struct packed {
    logic                  vld;
    logic                  deg;
    logic [2:0]            neg;
    logic [SW-1:0]         s;
    logic [2:0][RW-1:0]    r;
    logic [2:0][RW-1:0]    v;
    logic [2:0][QW-1:0]    q;
  } cell_t;

endpackage

FILE: hdl/tun_front.sv
`timescale 1ns / 1ps

module tun_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [31:0]  a_x,
  input  logic signed [31:0]  a_y,
  input  logic signed [31:0]  a_z,
  input  logic signed [31:0]  b_x,
  input  logic signed [31:0]  b_y,
  input  logic signed [31:0]  b_z,
  input  logic signed [31:0]  c_x,
  input  logic signed [31:0]  c_y,
  input  logic signed [31:0]  c_z,
  output tun_pkg::cell_t      head
);

  localparam int CW  = tun_pkg::CW;
  localparam int PW  = tun_pkg::PW;
  localparam int NW  = tun_pkg::NW;
  localparam int MW  = tun_pkg::MW;
  localparam int HW  = tun_pkg::HW;
  localparam int LW  = tun_pkg::LW;
  localparam int SQW = tun_pkg::SQW;
  localparam int SW  = tun_pkg::SW;
  localparam int RW  = tun_pkg::RW;
  localparam int WSH = tun_pkg::WSH;

  logic [6:0]              vld;
  logic signed [CW-1:0]    e1 [3];
  logic signed [CW-1:0]    e2 [3];
  logic signed [PW-1:0]    p [6];
  logic signed [NW-1:0]    n [3];
  logic signed [NW-1:0]    nabs [3];
  logic [MW-1:0]           mag [3];
  logic [2:0]              neg4;
  logic [2:0]              neg5;
  logic [2:0]              neg6;
  logic [2:0]              neg7;
  logic [2*HW-1:0]         hh [3];
  logic [HW+LW-1:0]        hl [3];
  logic [2*LW-1:0]         ll [3];
  logic [SQW-1:0]          sq [3];
  logic [SQW-1:0]          sq7 [3];
  logic [SW-1:0]           ssum;
  tun_pkg::cell_t          head_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:0], start};
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nabs[i] = n[i][NW-1] ? -n[i] : n[i];
    end
  end

  always_ff @(posedge clk) begin
    e1[0] <= {b_x[31], b_x} - {a_x[31], a_x};
    e1[1] <= {b_y[31], b_y} - {a_y[31], a_y};
    e1[2] <= {b_z[31], b_z} - {a_z[31], a_z};
    e2[0] <= {c_x[31], c_x} - {a_x[31], a_x};
    e2[1] <= {c_y[31], c_y} - {a_y[31], a_y};
    e2[2] <= {c_z[31], c_z} - {a_z[31], a_z};

    p[0] <= e1[1] * e2[2];
    p[1] <= e1[2] * e2[1];
    p[2] <= e1[2] * e2[0];
    p[3] <= e1[0] * e2[2];
    p[4] <= e1[0] * e2[1];
    p[5] <= e1[1] * e2[0];

    // true difference fits the signed width, so the wrap is harmless
    for (int i = 0; i < 3; i++) begin
      n[i]    <= p[2*i] - p[2*i+1];
      neg4[i] <= n[i][NW-1];
      mag[i]  <= nabs[i][MW-1:0];
      hh[i]   <= mag[i][MW-1:LW] * mag[i][MW-1:LW];
      hl[i]   <= mag[i][MW-1:LW] * mag[i][LW-1:0];
      ll[i]   <= mag[i][LW-1:0] * mag[i][LW-1:0];
      sq[i]   <= (SQW'(hh[i]) << (2*LW)) + (SQW'(hl[i]) << (LW+1)) + SQW'(ll[i]);
      sq7[i]  <= sq[i];
    end
    neg5 <= neg4;
    neg6 <= neg5;
    neg7 <= neg6;
    ssum <= SW'(sq[0]) + SW'(sq[1]) + SW'(sq[2]);
  end

  always_comb begin
    head_next.vld = vld[6];
    head_next.deg = (ssum == '0);
    head_next.neg = neg7;
    head_next.s   = ssum;
    for (int i = 0; i < 3; i++) begin
      // start from q = 0, i.e. 2q-1 = -1
      head_next.r[i] = (RW'(sq7[i]) << WSH) - RW'(ssum);
      head_next.v[i] = -RW'(ssum);
      head_next.q[i] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
    end else begin
      head <= head_next;
    end
  end

endmodule

FILE: hdl/tun_cell.sv
`timescale 1ns / 1ps

// Decides one magnitude bit K of all three components.
// Residue r = 2^30*n^2 - u^2*S with u = 2q-1, v = u*S.
module tun_cell #(
  parameter int K = 0
) (
  input  logic            clk,
  input  logic            rst,
  input  tun_pkg::cell_t  din,
  output tun_pkg::cell_t  dout
);

  localparam int RW = tun_pkg::RW;

  logic signed [RW-1:0]  trial [3];
  logic [2:0]            ok;
  tun_pkg::cell_t        dnext;

  always_comb begin
    dnext = din;
    for (int i = 0; i < 3; i++) begin
      trial[i] = $signed(din.r[i]) - ($signed(din.v[i]) <<< (K+2))
                 - $signed(RW'(din.s) << (2*K+2));
      ok[i] = !trial[i][RW-1];
      if (ok[i]) begin
        dnext.r[i] = trial[i];
        dnext.v[i] = din.v[i] + (RW'(din.s) << (K+1));
      end
      dnext.q[i][K] = ok[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout <= '0;
    end else begin
      dout <= dnext;
    end
  end

endmodule

FILE: hdl/triangle_unit_normal.sv
`timescale 1ns / 1ps
// Unit face normal of a triangle, Q16.16 vertices in, Q1.14 components out.
// Throughput: one request per cycle; busy is always low, the receiver cannot stall.
// Built from an 8-stage cross-product/square front end and a 15-cell bit chain.
// Reset clears all valid flags; in-flight requests are dropped.
module triangle_unit_normal (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic signed [31:0]  a_x,
  input  logic signed [31:0]  a_y,
  input  logic signed [31:0]  a_z,
  input  logic signed [31:0]  b_x,
  input  logic signed [31:0]  b_y,
  input  logic signed [31:0]  b_z,
  input  logic signed [31:0]  c_x,
  input  logic signed [31:0]  c_y,
  input  logic signed [31:0]  c_z,
  output logic                done,
  output logic signed [15:0]  normal_x,
  output logic signed [15:0]  normal_y,
  output logic signed [15:0]  normal_z,
  output logic                degenerate
);

  localparam int QW = tun_pkg::QW;
  localparam int OW = tun_pkg::OW;

  tun_pkg::cell_t     chain [QW+1];
  tun_pkg::cell_t     tail;
  logic [OW-1:0]      comp [3];

  assign busy = 1'b0;

  tun_front u_front (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .a_x   (a_x),
    .a_y   (a_y),
    .a_z   (a_z),
    .b_x   (b_x),
    .b_y   (b_y),
    .b_z   (b_z),
    .c_x   (c_x),
    .c_y   (c_y),
    .c_z   (c_z),
    .head  (chain[0])
  );

  for (genvar j = 0; j < QW; j++) begin : g_cell
    tun_cell #(
      .K (QW-1-j)
    ) u_cell (
      .clk  (clk),
      .rst  (rst),
      .din  (chain[j]),
      .dout (chain[j+1])
    );
  end

  assign tail = chain[QW];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (tail.deg) begin
        comp[i] = '0;
      end else if (tail.neg[i]) begin
        comp[i] = OW'(0) - OW'(tail.q[i]);
      end else begin
        comp[i] = OW'(tail.q[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= tail.vld;
    end
    normal_x   <= comp[0];
    normal_y   <= comp[1];
    normal_z   <= comp[2];
    degenerate <= tail.deg;
  end

endmodule
